// ----- rtl/core/uoas_pkg.sv -----
// Shared types, constants and helpers for the ultrasonic obstacle-avoid sequencer.
package uoas_pkg;

    localparam int DISTANCE_BITS = 10;
    localparam int TIMER_BITS    = 22;

    localparam int THR_W  = 10;
    localparam int TPC_W  = 8;
    localparam int TRIG_W = 8;
    localparam int TURN_W = 21;
    localparam int CFG_W  = 21;
    localparam int CFG_IDX_W = 2;

    // Width that holds a doubled turn length and the timer maximum alike
    localparam int LEN_W = (TURN_W + 1 > TIMER_BITS) ? TURN_W + 1 : TIMER_BITS;

    localparam logic [DISTANCE_BITS-1:0] DIST_MAX  = {DISTANCE_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0]    TIMER_MAX = {TIMER_BITS{1'b1}};

    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(15);
    localparam logic [TPC_W-1:0]  TPC_RST       = TPC_W'(58);
    localparam logic [TRIG_W-1:0] TRIG_RST      = TRIG_W'(10);
    localparam logic [TURN_W-1:0] TURN_RST      = TURN_W'(1000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_TPC       = 2'd1,
        CFG_TRIGGER   = 2'd2,
        CFG_TURN      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_cm;
        logic [TPC_W-1:0]  ticks_per_cm;
        logic [TRIG_W-1:0] trigger_ticks;
        logic [TURN_W-1:0] turn_ticks;
    } t_cfg;

    typedef enum logic [2:0] {
        MV_FORWARD = 3'd0,
        MV_REVERSE = 3'd1,
        MV_RIGHT   = 3'd2,
        MV_LEFT    = 3'd3,
        MV_STOP    = 3'd4
    } t_motion;

    typedef enum logic [12:0] {
        PH_FRONT_TRIG = 13'b0000000000001,
        PH_FRONT_WAIT = 13'b0000000000010,
        PH_FRONT_CNT  = 13'b0000000000100,
        PH_TURN_R1    = 13'b0000000001000,
        PH_RIGHT_TRIG = 13'b0000000010000,
        PH_RIGHT_WAIT = 13'b0000000100000,
        PH_RIGHT_CNT  = 13'b0000001000000,
        PH_TURN_L2    = 13'b0000010000000,
        PH_LEFT_TRIG  = 13'b0000100000000,
        PH_LEFT_WAIT  = 13'b0001000000000,
        PH_LEFT_CNT   = 13'b0010000000000,
        PH_TURN_BACK  = 13'b0100000000000,
        PH_TURN_FINAL = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic                     trigger_out;
        logic                     left_motor_a;
        logic                     left_motor_b;
        logic                     right_motor_a;
        logic                     right_motor_b;
        logic [DISTANCE_BITS-1:0] distance_cm;
        logic                     distance_done;
    } t_result;

    function automatic logic [7:0] at_least_one8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Clamp a turn length to the timer range, zero counts as one
    function automatic logic [LEN_W-1:0] turn_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] len;
        len = raw;
        if (len > LEN_W'(TIMER_MAX)) len = LEN_W'(TIMER_MAX);
        if (len == '0) len = LEN_W'(1);
        return len;
    endfunction

endpackage

// ----- rtl/core/uoas_seq.sv -----
// Sequencer state and per-tick next-state and result logic.
module uoas_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_echo_level,
    input  uoas_pkg::t_cfg   i_cfg,
    output uoas_pkg::t_result o_res
);
    import uoas_pkg::*;

    t_phase                   r_phase,    n_phase;
    t_motion                  r_motion,   n_motion;
    logic [TIMER_BITS-1:0]    r_timer,    n_timer;
    logic [TPC_W-1:0]         r_window,   n_window;
    logic [DISTANCE_BITS-1:0] r_dist,     n_dist;
    logic [DISTANCE_BITS-1:0] r_right,    n_right;
    logic [DISTANCE_BITS-1:0] r_left,     n_left;
    logic [DISTANCE_BITS-1:0] r_last,     n_last;

    logic [TIMER_BITS-1:0] timer_inc;
    logic [LEN_W-1:0]      len_one, len_two;
    logic                  trig_end, turn1_end, turn2_end;
    logic [TPC_W-1:0]      window_reload;
    logic                  done;
    logic                  la, lb, ra, rb;

    assign timer_inc     = r_timer + 1'b1;
    assign len_one       = turn_len(LEN_W'(i_cfg.turn_ticks));
    assign len_two       = turn_len({len_one[LEN_W-2:0], 1'b0});
    assign trig_end      = timer_inc >= TIMER_BITS'(at_least_one8(i_cfg.trigger_ticks));
    assign turn1_end     = LEN_W'(timer_inc) >= len_one;
    assign turn2_end     = LEN_W'(timer_inc) >= len_two;
    assign window_reload = at_least_one8(i_cfg.ticks_per_cm) - 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_motion = r_motion;
        n_timer  = r_timer;
        n_window = r_window;
        n_dist   = r_dist;
        n_right  = r_right;
        n_left   = r_left;
        n_last   = r_last;
        done     = 1'b0;
        case (r_phase)
            PH_FRONT_TRIG, PH_RIGHT_TRIG, PH_LEFT_TRIG: begin
                n_timer = timer_inc;
                if (trig_end) begin
                    n_phase = (r_phase == PH_FRONT_TRIG) ? PH_FRONT_WAIT :
                              (r_phase == PH_RIGHT_TRIG) ? PH_RIGHT_WAIT : PH_LEFT_WAIT;
                end
            end
            PH_FRONT_WAIT, PH_RIGHT_WAIT, PH_LEFT_WAIT: begin
                if (i_echo_level) begin
                    n_dist   = DISTANCE_BITS'(1);
                    n_window = window_reload;
                    n_phase  = (r_phase == PH_FRONT_WAIT) ? PH_FRONT_CNT :
                               (r_phase == PH_RIGHT_WAIT) ? PH_RIGHT_CNT : PH_LEFT_CNT;
                end
            end
            PH_FRONT_CNT, PH_RIGHT_CNT, PH_LEFT_CNT: begin
                if (r_window != '0) begin
                    n_window = r_window - 1'b1;
                end else if (i_echo_level) begin
                    if (r_dist != DIST_MAX) n_dist = r_dist + 1'b1;
                    n_window = window_reload;
                end else begin
                    done    = 1'b1;
                    n_last  = r_dist;
                    n_timer = '0;
                    if (r_phase == PH_FRONT_CNT) begin
                        if (THR_W'(r_dist) > i_cfg.threshold_cm) begin
                            n_motion = MV_FORWARD;
                            n_phase  = PH_FRONT_TRIG;
                            n_window = '0;
                            n_dist   = '0;
                        end else begin
                            n_motion = MV_RIGHT;
                            n_phase  = PH_TURN_R1;
                        end
                    end else if (r_phase == PH_RIGHT_CNT) begin
                        n_right  = r_dist;
                        n_motion = MV_LEFT;
                        n_phase  = PH_TURN_L2;
                    end else begin
                        n_left   = r_dist;
                        n_motion = MV_RIGHT;
                        n_phase  = PH_TURN_BACK;
                    end
                end
            end
            PH_TURN_R1, PH_TURN_FINAL: begin
                n_timer = timer_inc;
                if (turn1_end) begin
                    n_motion = MV_STOP;
                    n_phase  = (r_phase == PH_TURN_R1) ? PH_RIGHT_TRIG : PH_FRONT_TRIG;
                    n_timer  = '0;
                    n_window = '0;
                    n_dist   = '0;
                end
            end
            PH_TURN_L2: begin
                n_timer = timer_inc;
                if (turn2_end) begin
                    n_motion = MV_STOP;
                    n_phase  = PH_LEFT_TRIG;
                    n_timer  = '0;
                    n_window = '0;
                    n_dist   = '0;
                end
            end
            PH_TURN_BACK: begin
                n_timer = timer_inc;
                if (turn1_end) begin
                    n_motion = (r_right >= r_left) ? MV_RIGHT : MV_LEFT;
                    n_phase  = PH_TURN_FINAL;
                    n_timer  = '0;
                end
            end
            default: begin
                n_phase  = PH_FRONT_TRIG;
                n_timer  = '0;
                n_window = '0;
                n_dist   = '0;
            end
        endcase
    end

    always_comb begin
        la = 1'b0; lb = 1'b0; ra = 1'b0; rb = 1'b0;
        case (r_motion)
            MV_FORWARD: begin lb = 1'b1; rb = 1'b1; end
            MV_REVERSE: begin la = 1'b1; ra = 1'b1; end
            MV_RIGHT:   begin lb = 1'b1; ra = 1'b1; end
            MV_LEFT:    begin la = 1'b1; rb = 1'b1; end
            default: begin end
        endcase
    end

    always_comb begin
        o_res.trigger_out   = (r_phase == PH_FRONT_TRIG) || (r_phase == PH_RIGHT_TRIG) ||
                              (r_phase == PH_LEFT_TRIG);
        o_res.left_motor_a  = la;
        o_res.left_motor_b  = lb;
        o_res.right_motor_a = ra;
        o_res.right_motor_b = rb;
        o_res.distance_cm   = n_last;
        o_res.distance_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FRONT_TRIG;
            r_motion <= MV_STOP;
            r_timer  <= '0;
            r_window <= '0;
            r_dist   <= '0;
            r_right  <= '0;
            r_left   <= '0;
            r_last   <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_motion <= n_motion;
            r_timer  <= n_timer;
            r_window <= n_window;
            r_dist   <= n_dist;
            r_right  <= n_right;
            r_left   <= n_left;
            r_last   <= n_last;
        end
    end

`ifndef SYNTHESIS
    // Side measurements are always taken with the motors stopped
    a_stop_while_ranging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RIGHT_TRIG || r_phase == PH_RIGHT_WAIT || r_phase == PH_RIGHT_CNT ||
         r_phase == PH_LEFT_TRIG || r_phase == PH_LEFT_WAIT || r_phase == PH_LEFT_CNT)
        |-> r_motion == MV_STOP)
        else $error("motors running during side measurement");

    // The first right turn and the turn back drive the right-turn code
    a_turn_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TURN_R1 || r_phase == PH_TURN_BACK) |-> r_motion == MV_RIGHT)
        else $error("right turn phase without right motion");

    a_final_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TURN_FINAL |-> (r_motion == MV_RIGHT || r_motion == MV_LEFT))
        else $error("final turn without a turn code");

    // A close front reading always starts the scan
    a_obstacle_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_phase == PH_FRONT_CNT && done &&
         THR_W'(r_dist) <= i_cfg.threshold_cm)
        |=> (r_phase == PH_TURN_R1 && r_motion == MV_RIGHT && r_timer == '0))
        else $error("obstacle did not start the scan");
`endif

endmodule

// ----- rtl/core/ultrasonic_obstacle_avoid_sequencer.sv -----
// Top level of the ultrasonic obstacle-avoid sequencer: handshake, registers, result word.
//
// One input word is one microsecond tick with the sampled echo level; every tick gives
// exactly one result word. The sequencer state and all per-tick logic sit between the
// input handshake and a single output register, so a result appears in the cycle after
// its tick is accepted. Throughput is one tick per cycle while the output side takes
// words; when the output is stalled with a word held, the input is stalled in the same
// cycle, so the output register is the only buffer. A measurement lasts trigger_ticks
// ticks of trigger, then an unbounded wait for echo rise, then ticks_per_cm ticks per
// centimetre window until a window start sees the echo low; the turns last turn_ticks
// ticks, twice that for the long left turn.
// Configuration words are taken on any cycle with i_cfg_we high and apply at once.
module ultrasonic_obstacle_avoid_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [uoas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [uoas_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_echo_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_trigger_out,
    output logic                              o_left_motor_a,
    output logic                              o_left_motor_b,
    output logic                              o_right_motor_a,
    output logic                              o_right_motor_b,
    output logic [uoas_pkg::DISTANCE_BITS-1:0] o_distance_cm,
    output logic                              o_distance_done
);
    import uoas_pkg::*;

    t_cfg    r_cfg;
    t_result r_out, seq_res;
    logic    r_out_valid;
    logic    adv;

    // Take a tick unless a finished word is held back by the output side
    assign o_in_stall = r_out_valid && i_out_stall;
    assign adv        = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_cm  <= THRESHOLD_RST;
            r_cfg.ticks_per_cm  <= TPC_RST;
            r_cfg.trigger_ticks <= TRIG_RST;
            r_cfg.turn_ticks    <= TURN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_cfg.threshold_cm  <= i_cfg_data[THR_W-1:0];
                CFG_TPC:       r_cfg.ticks_per_cm  <= i_cfg_data[TPC_W-1:0];
                CFG_TRIGGER:   r_cfg.trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                CFG_TURN:      r_cfg.turn_ticks    <= i_cfg_data[TURN_W-1:0];
                default: begin end
            endcase
        end
    end

    uoas_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_echo_level (i_echo_level),
        .i_cfg        (r_cfg),
        .o_res        (seq_res)
    );

    // Result word register; the payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_out   = r_out.trigger_out;
    assign o_left_motor_a  = r_out.left_motor_a;
    assign o_left_motor_b  = r_out.left_motor_b;
    assign o_right_motor_a = r_out.right_motor_a;
    assign o_right_motor_b = r_out.right_motor_b;
    assign o_distance_cm   = r_out.distance_cm;
    assign o_distance_done = r_out.distance_done;

endmodule

// ----- tb/tb_ultrasonic_obstacle_avoid_sequencer.sv -----
// Self-checking testbench for the ultrasonic obstacle-avoid sequencer.
module tb_ultrasonic_obstacle_avoid_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import uoas_pkg::*;

    // Run shape
    localparam int unsigned ITEM_GOAL   = 1350;  // ticks in the whole run
    localparam int unsigned SAT_RUN     = 1030;  // echo high long enough to pin the count
    localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no word moving on either side

    // Directed echo patterns, sent MSB first.
    // Walk: one whole avoid cycle with zero-as-one settings, including a wait
    // before the echo rises and a left reading larger than the right one.
    localparam logic [16:0] WALK_BITS = 17'b00110001000011000;
    // Skip: low levels between window starts must be ignored.
    localparam logic [7:0]  SKIP_BITS = 8'b10100110;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_echo_level;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_trigger_out;
    logic                     o_left_motor_a;
    logic                     o_left_motor_b;
    logic                     o_right_motor_a;
    logic                     o_right_motor_b;
    logic [DISTANCE_BITS-1:0] o_distance_cm;
    logic                     o_distance_done;

    // ------------------------------------------------------------------
    // Scoreboard: shadow sequencer plus the queue of pin words still due.
    // ------------------------------------------------------------------
    class avoid_scoreboard;
        t_result                  pin_words_due[$];
        int unsigned              errors;

        // shadow registers
        logic [THR_W-1:0]         thr_cm;
        logic [TPC_W-1:0]         tpc;
        logic [TRIG_W-1:0]        trig_len;
        logic [TURN_W-1:0]        turn_base;

        // shadow sequencer state
        t_phase                   ph;
        t_motion                  mv;
        logic [TIMER_BITS-1:0]    timer;
        logic [7:0]               win;
        logic [DISTANCE_BITS-1:0] dist_cnt;
        logic [DISTANCE_BITS-1:0] right_d;
        logic [DISTANCE_BITS-1:0] left_d;
        logic [DISTANCE_BITS-1:0] last_d;

        function new();
            errors    = 0;
            thr_cm    = THR_W'(15);
            tpc       = TPC_W'(58);
            trig_len  = TRIG_W'(10);
            turn_base = TURN_W'(1000000);
            right_d   = '0;
            left_d    = '0;
            last_d    = '0;
            mv        = MV_STOP;
            start_measure(PH_FRONT_TRIG);
        endfunction

        function logic [7:0] floor_one(logic [7:0] v);
            return (v == 8'd0) ? 8'd1 : v;
        endfunction

        function void start_measure(t_phase p);
            ph       = p;
            timer    = '0;
            win      = '0;
            dist_cnt = '0;
        endfunction

        function void start_turn(t_phase p, t_motion m);
            ph    = p;
            mv    = m;
            timer = '0;
        endfunction

        // One tick of a measurement; returns 1 on the tick it completes
        function bit measure_step(logic echo, t_phase wait_ph, t_phase cnt_ph);
            bit done;
            done = 1'b0;
            if (ph != wait_ph && ph != cnt_ph) begin
                timer = timer + 1'b1;
                if (timer >= TIMER_BITS'(floor_one(trig_len))) ph = wait_ph;
            end else if (ph == wait_ph) begin
                // rise tick is the first window start
                if (echo) begin
                    dist_cnt = DISTANCE_BITS'(1);
                    win      = floor_one(tpc) - 8'd1;
                    ph       = cnt_ph;
                end
            end else if (win != 8'd0) begin
                win = win - 8'd1;
            end else if (echo) begin
                if (dist_cnt != DIST_MAX) dist_cnt = dist_cnt + 1'b1;
                win = floor_one(tpc) - 8'd1;
            end else begin
                last_d = dist_cnt;
                done   = 1'b1;
            end
            return done;
        endfunction

        function bit turn_step(logic [TIMER_BITS-1:0] len);
            timer = timer + 1'b1;
            return timer >= len;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: thr_cm    = data[THR_W-1:0];
                CFG_TPC:       tpc       = data[TPC_W-1:0];
                CFG_TRIGGER:   trig_len  = data[TRIG_W-1:0];
                CFG_TURN:      turn_base = data[TURN_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the shadow by one accepted tick and queue the pin word it gives
        function void advance_tick(logic echo);
            t_result               w;
            logic [TIMER_BITS-1:0] one_len;
            w = '0;
            one_len = (turn_base == '0) ? TIMER_BITS'(1) : TIMER_BITS'(turn_base);
            w.trigger_out = (ph == PH_FRONT_TRIG) || (ph == PH_RIGHT_TRIG) ||
                            (ph == PH_LEFT_TRIG);
            case (mv)
                MV_FORWARD: begin w.left_motor_b = 1'b1; w.right_motor_b = 1'b1; end
                MV_REVERSE: begin w.left_motor_a = 1'b1; w.right_motor_a = 1'b1; end
                MV_RIGHT:   begin w.left_motor_b = 1'b1; w.right_motor_a = 1'b1; end
                MV_LEFT:    begin w.left_motor_a = 1'b1; w.right_motor_b = 1'b1; end
                default: ;
            endcase
            case (ph)
                PH_FRONT_TRIG, PH_FRONT_WAIT, PH_FRONT_CNT: begin
                    if (measure_step(echo, PH_FRONT_WAIT, PH_FRONT_CNT)) begin
                        w.distance_done = 1'b1;
                        if (last_d > thr_cm) begin
                            mv = MV_FORWARD;
                            start_measure(PH_FRONT_TRIG);
                        end else begin
                            start_turn(PH_TURN_R1, MV_RIGHT);
                        end
                    end
                end
                PH_TURN_R1: begin
                    if (turn_step(one_len)) begin
                        mv = MV_STOP;
                        start_measure(PH_RIGHT_TRIG);
                    end
                end
                PH_RIGHT_TRIG, PH_RIGHT_WAIT, PH_RIGHT_CNT: begin
                    if (measure_step(echo, PH_RIGHT_WAIT, PH_RIGHT_CNT)) begin
                        w.distance_done = 1'b1;
                        right_d = last_d;
                        start_turn(PH_TURN_L2, MV_LEFT);
                    end
                end
                PH_TURN_L2: begin
                    // doubled 21-bit length always fits the 22-bit timer
                    if (turn_step(one_len << 1)) begin
                        mv = MV_STOP;
                        start_measure(PH_LEFT_TRIG);
                    end
                end
                PH_LEFT_TRIG, PH_LEFT_WAIT, PH_LEFT_CNT: begin
                    if (measure_step(echo, PH_LEFT_WAIT, PH_LEFT_CNT)) begin
                        w.distance_done = 1'b1;
                        left_d = last_d;
                        start_turn(PH_TURN_BACK, MV_RIGHT);
                    end
                end
                PH_TURN_BACK: begin
                    // tie goes right
                    if (turn_step(one_len))
                        start_turn(PH_TURN_FINAL, (right_d >= left_d) ? MV_RIGHT : MV_LEFT);
                end
                PH_TURN_FINAL: begin
                    if (turn_step(one_len)) begin
                        mv = MV_STOP;
                        start_measure(PH_FRONT_TRIG);
                    end
                end
                default: start_measure(PH_FRONT_TRIG);
            endcase
            w.distance_cm = last_d;
            pin_words_due.push_back(w);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pin_words_due.size() == 0) begin
                $error("result word with nothing due");
                errors++;
                return;
            end
            want = pin_words_due.pop_front();
            compare_field("trigger_out",   16'(want.trigger_out),   16'(got.trigger_out));
            compare_field("left_motor_a",  16'(want.left_motor_a),  16'(got.left_motor_a));
            compare_field("left_motor_b",  16'(want.left_motor_b),  16'(got.left_motor_b));
            compare_field("right_motor_a", 16'(want.right_motor_a), 16'(got.right_motor_a));
            compare_field("right_motor_b", 16'(want.right_motor_b), 16'(got.right_motor_b));
            compare_field("distance_cm",   16'(want.distance_cm),   16'(got.distance_cm));
            compare_field("distance_done", 16'(want.distance_done), 16'(got.distance_done));
        endfunction

        function int unsigned pending();
            return pin_words_due.size();
        endfunction

        function bit at_front();
            return (ph == PH_FRONT_TRIG) || (ph == PH_FRONT_WAIT) || (ph == PH_FRONT_CNT);
        endfunction
    endclass

    avoid_scoreboard sb = new();

    // Shared between the sender, the receiver and the phase sequencing
    int unsigned ticks_sent;
    bit          tx_gappy;
    bit          rx_gappy;
    bit          hold_req;
    bit          run_high;      // level of the current echo run
    int unsigned run_left;      // ticks left in the current echo run

    ultrasonic_obstacle_avoid_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_trigger_out   (o_trigger_out),
        .o_left_motor_a  (o_left_motor_a),
        .o_left_motor_b  (o_left_motor_b),
        .o_right_motor_a (o_right_motor_a),
        .o_right_motor_b (o_right_motor_b),
        .o_distance_cm   (o_distance_cm),
        .o_distance_done (o_distance_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly none, sometimes a few cycles, rarely a long pause
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Echo as alternating runs: the high runs span a few centimetre windows
    // so that readings land either side of the threshold; one tick in
    // twenty is noise, which breaks runs up mid-window.
    function automatic logic next_echo();
        int unsigned span;
        int unsigned wins;
        if (run_left == 0) begin
            run_high = !run_high;
            span = (sb.tpc == '0) ? 1 : sb.tpc;
            if (run_high) begin
                wins = (span > 64) ? $urandom_range(1, 2) : $urandom_range(1, 12);
                run_left = wins * span - $urandom_range(0, span - 1);
            end else begin
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 6);
            end
        end
        run_left--;
        if ($urandom_range(0, 19) == 0) return 1'($urandom_range(0, 1));
        return run_high;
    endfunction

    // Offer one tick word, hold it until taken, then maybe leave a gap
    task automatic send_tick(input logic echo);
        int unsigned gap;
        i_in_valid   <= 1'b1;
        i_echo_level <= echo;
        do @(posedge i_clk); while (!(i_in_valid === 1'b1 && o_in_stall === 1'b0));
        sb.advance_tick(echo);
        ticks_sent++;
        gap = tx_gappy ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid   <= 1'b0;
            i_echo_level <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender stops until every pin word due has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_word(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Write all four registers back to back; only while idle
    task automatic set_regs(input logic [THR_W-1:0] thr, input logic [TPC_W-1:0] tpc,
                            input logic [TRIG_W-1:0] trig, input logic [TURN_W-1:0] turn);
        cfg_word(CFG_THRESHOLD, CFG_W'(thr));
        cfg_word(CFG_TPC,       CFG_W'(tpc));
        cfg_word(CFG_TRIGGER,   CFG_W'(trig));
        cfg_word(CFG_TURN,      CFG_W'(turn));
        i_cfg_we <= 1'b0;
    endtask

    // Small settings that keep whole avoid cycles short; zero now and then
    task automatic random_regs();
        logic [THR_W-1:0]  thr;
        logic [TPC_W-1:0]  tpc;
        logic [TRIG_W-1:0] trig;
        logic [TURN_W-1:0] turn;
        int unsigned       r;
        r = $urandom_range(0, 9);
        thr  = (r == 0) ? '0 : (r == 1) ? '1 : THR_W'($urandom_range(0, 10));
        tpc  = ($urandom_range(0, 7) == 0) ? '0 : TPC_W'($urandom_range(1, 4));
        trig = ($urandom_range(0, 7) == 0) ? '0 : TRIG_W'($urandom_range(1, 4));
        turn = ($urandom_range(0, 7) == 0) ? '0 : TURN_W'($urandom_range(1, 6));
        set_regs(thr, tpc, trig, turn);
    endtask

    task automatic run_phase(input int unsigned n);
        repeat (n) send_tick(next_echo());
    endtask

    // Receiver: takes pin words, stalls at random, and honours one long hold-off
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned r;
        t_result     got;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got.trigger_out   = o_trigger_out;
                got.left_motor_a  = o_left_motor_a;
                got.left_motor_b  = o_left_motor_b;
                got.right_motor_a = o_right_motor_a;
                got.right_motor_b = o_right_motor_b;
                got.distance_cm   = o_distance_cm;
                got.distance_done = o_distance_done;
                sb.check_word(got);
            end
            if (hold_left == 0) begin
                if (hold_req) begin
                    hold_left = HOLD_CYCLES;
                    hold_req  = 1'b0;
                end else if (rx_gappy) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)      hold_left = 0;
                    else if (r < 95) hold_left = $urandom_range(1, 3);
                    else             hold_left = $urandom_range(10, 30);
                end
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Main sequence
    initial begin : stimulus
        int i;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_THRESHOLD;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_echo_level = 1'b0;
        ticks_sent   = 0;
        tx_gappy     = 1'b0;
        rx_gappy     = 1'b0;
        hold_req     = 1'b0;
        run_high     = 1'b1;
        run_left     = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a few ticks at reset settings (trigger high, robot stopped)
        repeat (4) send_tick(1'b0);

        // Threshold at its top, every length register zero so each acts as one
        drain();
        set_regs('1, '0, '0, '0);
        for (i = 16; i >= 0; i--) send_tick(WALK_BITS[i]);

        // Two-tick windows: lows that fall between window starts go unseen
        drain();
        set_regs(THR_W'(3), TPC_W'(2), TRIG_W'(1), TURN_W'(1));
        for (i = 7; i >= 0; i--) send_tick(SKIP_BITS[i]);

        // Sender keeps offering through a long receiver hold-off, so the
        // block fills and stalls its input
        drain();
        random_regs();
        tx_gappy = 1'b0;
        rx_gappy = 1'b1;
        hold_req = 1'b1;
        run_phase(120);

        // Longest turn and trigger: only safe from a front measurement with
        // threshold zero, which keeps the robot driving forward
        while (!sb.at_front()) send_tick(next_echo());
        drain();
        tx_gappy = 1'b1;
        set_regs('0, TPC_W'(1), '1, '1);
        run_phase(60);

        // Widest centimetre window
        drain();
        set_regs(THR_W'($urandom_range(0, 3)), '1, TRIG_W'(1), TURN_W'(1));
        run_phase(60);

        // Echo held high until the distance count saturates
        drain();
        set_regs('1, TPC_W'(1), TRIG_W'(1), TURN_W'(2));
        repeat (3) send_tick(1'b0);
        repeat (SAT_RUN) send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // Random phases with fresh settings and idling modes each time
        while (ticks_sent < ITEM_GOAL) begin
            drain();
            random_regs();
            tx_gappy = ($urandom_range(0, 3) != 0);
            rx_gappy = ($urandom_range(0, 3) != 0);
            run_phase($urandom_range(30, 80));
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
